>>> sv/scba_pkg.sv
package scba_pkg;

  localparam int NUM_BANKS     = 16;
  localparam int DIR_SIZE_BITS = 12;

  localparam int BANK_W   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int KIND_W   = 2;
  localparam int SID_W    = 15;
  localparam int ASID_W   = 5;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 48;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [SID_W-1:0] STREAM_FREE = SID_W'(8'hFF);

  typedef enum logic [KIND_W-1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LOOKUP  = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND = 2'd0,
    ST_DONE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

endpackage

>>> sv/stream_id_context_bank_allocator.sv
// Stream-ID context bank allocator.
// Requests enter on the in_ stream channel: kind (acquire, release, lookup),
// a stream ID and a bank number plus one. Each request gives exactly one
// result on the out_ channel: bank number plus one, a status code and a
// page-directory address.
// An acquire walks the bank table with one shared comparator, one bank per
// cycle, and stops at the first in-use bank with a matching stream ID; a
// miss claims the lowest free bank seen during the walk. An acquire passes
// through an accept step, the scan steps (up to the matching bank, at most
// NUM_BANKS banks) and a completion step. Release, lookup and unknown
// kinds skip the walk and go from the accept step straight to completion.
// One request is worked on at a time; in_tready is high only when idle.
// The result sits in an output register, so a new request is taken while
// the previous result still waits. If the receiver stalls and a finished
// request finds the output register occupied, it waits in the completion
// step, and neither the table nor the result changes until the slot frees.
// The page-directory base is written through the cfg_ APB port when
// address bit 3 is clear. Reset frees every bank and clears the base to zero.
module stream_id_context_bank_allocator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] kind, [16:2] stream_id, [21:17] bank_asid, rest zero.
  input  logic [scba_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [4:0] result_asid, [6:5] status, [54:7] page_dir_addr, rest zero.
  output logic [scba_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [scba_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [scba_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [scba_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  localparam int BW = scba_pkg::BANK_W;
  localparam int AW = scba_pkg::ASID_W;
  localparam int SW = scba_pkg::SID_W;
  localparam int DW = scba_pkg::ADDR_W;

  scba_pkg::state_t state_r, state_nxt;

  logic [DW-1:0]              base_r;
  logic [scba_pkg::NUM_BANKS-1:0] in_use_r;
  logic [SW-1:0]              stream_r [scba_pkg::NUM_BANKS];

  logic [scba_pkg::KIND_W-1:0] kind_r;
  logic [SW-1:0]              sid_r;
  logic [BW-1:0]              idx_r;
  logic                       bad_r;
  logic [BW-1:0]              cnt_r, cnt_nxt;
  logic                       hit_r, hit_nxt;
  logic [BW-1:0]              hit_idx_r, hit_idx_nxt;
  logic                       free_r, free_nxt;
  logic [BW-1:0]              free_idx_r, free_idx_nxt;

  logic                       out_valid_r;
  logic [AW-1:0]              out_asid_r, out_asid_nxt;
  scba_pkg::status_t          out_status_r, out_status_nxt;
  logic [DW-1:0]              out_addr_r, out_addr_nxt;

  logic                       in_acc;
  logic                       out_load;
  logic                       slot_free;
  logic                       cfg_wr;
  logic                       scan_match;
  logic                       scan_last;
  logic                       rel_wr;
  logic                       alloc_wr;
  logic [AW-1:0]              in_asid;
  logic                       in_bad;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & ~cfg_paddr[3];
  assign cfg_prdata = cfg_paddr[3] ? '0 : {{(scba_pkg::CFG_DATA_W-DW){1'b0}}, base_r};

  assign in_tready  = (state_r == scba_pkg::S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign slot_free  = ~out_valid_r | out_tready;

  assign in_asid = in_tdata[21:17];
  assign in_bad  = (in_asid == '0) || (32'(in_asid) > scba_pkg::NUM_BANKS);

  assign scan_match = in_use_r[cnt_r] && (stream_r[cnt_r] == sid_r);
  assign scan_last  = (32'(cnt_r) == scba_pkg::NUM_BANKS - 1);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(scba_pkg::OUT_DATA_W-DW-scba_pkg::STATUS_W-AW){1'b0}},
                       out_addr_r, out_status_r, out_asid_r};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    out_load       = 1'b0;
    rel_wr         = 1'b0;
    alloc_wr       = 1'b0;
    out_asid_nxt   = '0;
    out_status_nxt = scba_pkg::ST_BAD;
    out_addr_nxt   = '0;
    unique case (state_r)
      scba_pkg::S_IDLE: begin
        if (in_acc) begin
          cnt_nxt  = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          if (in_tdata[1:0] == scba_pkg::KIND_ACQUIRE) begin
            state_nxt = scba_pkg::S_SCAN;
          end else begin
            state_nxt = scba_pkg::S_DONE;
          end
        end
      end
      scba_pkg::S_SCAN: begin
        if (!in_use_r[cnt_r] && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cnt_r;
        end
        if (scan_match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cnt_r;
          state_nxt   = scba_pkg::S_DONE;
        end else if (scan_last) begin
          state_nxt = scba_pkg::S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      scba_pkg::S_DONE: begin
        priority if (kind_r == scba_pkg::KIND_ACQUIRE) begin
          if (hit_r) begin
            out_asid_nxt   = AW'(32'(hit_idx_r) + 32'd1);
            out_status_nxt = scba_pkg::ST_FOUND;
          end else if (free_r) begin
            out_asid_nxt   = AW'(32'(free_idx_r) + 32'd1);
            out_status_nxt = scba_pkg::ST_DONE;
            alloc_wr       = 1'b1;
          end else begin
            out_status_nxt = scba_pkg::ST_FULL;
          end
        end else if (kind_r == scba_pkg::KIND_RELEASE && !bad_r) begin
          out_status_nxt = scba_pkg::ST_DONE;
          rel_wr         = 1'b1;
        end else if (kind_r == scba_pkg::KIND_LOOKUP && !bad_r) begin
          out_status_nxt = scba_pkg::ST_DONE;
          out_addr_nxt   = base_r + (DW'(idx_r) << scba_pkg::DIR_SIZE_BITS);
        end else begin
          out_status_nxt = scba_pkg::ST_BAD;
        end
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = scba_pkg::S_IDLE;
        end else begin
          rel_wr   = 1'b0;
          alloc_wr = 1'b0;
        end
      end
      default: begin
        state_nxt = scba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scba_pkg::S_IDLE;
      base_r      <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      hit_r   <= hit_nxt;
      free_r  <= free_nxt;
      if (cfg_wr) begin
        base_r <= cfg_pwdata[DW-1:0];
      end
      if (alloc_wr) begin
        in_use_r[free_idx_r] <= 1'b1;
      end
      if (rel_wr) begin
        in_use_r[idx_r] <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    if (in_acc) begin
      kind_r <= in_tdata[1:0];
      sid_r  <= in_tdata[16:2];
      bad_r  <= in_bad;
      idx_r  <= in_bad ? '0 : BW'(32'(in_asid) - 32'd1);
    end
    if (alloc_wr) begin
      stream_r[free_idx_r] <= sid_r;
    end
    if (rel_wr) begin
      stream_r[idx_r] <= scba_pkg::STREAM_FREE;
    end
    if (out_load) begin
      out_asid_r   <= out_asid_nxt;
      out_status_r <= out_status_nxt;
      out_addr_r   <= out_addr_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_full_all_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == scba_pkg::ST_FULL |-> &in_use_r)
    else $error("full reported while a bank is free");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == scba_pkg::S_SCAN |-> 32'(cnt_r) < scba_pkg::NUM_BANKS)
    else $error("scan index out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == scba_pkg::ST_FULL || out_status_r == scba_pkg::ST_BAD)
    |-> out_asid_r == '0 && out_addr_r == '0)
    else $error("failed request carries a bank or address");
`endif

endmodule
